// ===== design/paired_endpoint_relay_table_core_macros.svh =====
// Assertion macros shared by the relay table modules.
`ifndef PAIRED_ENDPOINT_RELAY_TABLE_CORE_MACROS_SVH
`define PAIRED_ENDPOINT_RELAY_TABLE_CORE_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PERT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define PERT_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/pert_pkg.sv =====
// Types, codes and constants of the relay forwarding table.
package pert_pkg;

	localparam int PEER_SLOTS_DEF = 16;
	localparam int SLOT_W         = 4;
	localparam int ADDR_W         = 64;
	localparam int PORT_W         = 16;
	localparam int LEN_W          = 16;
	localparam int CNT_W          = 64;
	localparam logic [31:0] MAPPED_PREFIX = 32'h0000_FFFF;

	localparam logic [2:0] CMD_PACKET      = 3'd0;
	localparam logic [2:0] CMD_PEER_ADD    = 3'd1;
	localparam logic [2:0] CMD_PEER_REMOVE = 3'd2;
	localparam logic [2:0] CMD_LINK_ADD    = 3'd3;
	localparam logic [2:0] CMD_LINK_REMOVE = 3'd4;
	localparam logic [2:0] CMD_PEER_READ   = 3'd5;
	localparam logic [2:0] CMD_STATS_READ  = 3'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNKNOWN   = 3'd1;
	localparam logic [2:0] ST_SELF_LINK = 3'd2;
	localparam logic [2:0] ST_LINKED    = 3'd3;
	localparam logic [2:0] ST_DUP_LINK  = 3'd4;
	localparam logic [2:0] ST_NO_LINK   = 3'd5;
	localparam logic [2:0] ST_TAKEN     = 3'd6;
	localparam logic [2:0] ST_NOT_FOUND = 3'd7;

	typedef struct packed {
		logic [2:0]        command;
		logic [SLOT_W-1:0] slot_a;
		logic [SLOT_W-1:0] slot_b;
		logic [ADDR_W-1:0] address_high;
		logic [ADDR_W-1:0] address_low;
		logic [PORT_W-1:0] port_number;
		logic              is_v6;
		logic [LEN_W-1:0]  packet_length;
		logic [63:0]       timestamp;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] source_slot;
		logic [SLOT_W-1:0] dest_slot;
		logic [ADDR_W-1:0] dest_address_high;
		logic [ADDR_W-1:0] dest_address_low;
		logic [PORT_W-1:0] dest_port;
		logic              dest_is_v6;
		logic [CNT_W-1:0]  value_a;
		logic [CNT_W-1:0]  value_b;
		logic [CNT_W-1:0]  value_c;
		logic [CNT_W-1:0]  value_d;
	} out_item_t;

endpackage

// ===== design/pert_match.sv =====
// Parallel endpoint compare over all peer slots with lowest-slot priority.
module pert_match #(
	parameter int SLOTS = pert_pkg::PEER_SLOTS_DEF,
	parameter int IDX_W = $clog2(SLOTS)
) (
	input  logic                        valid [SLOTS],
	input  logic                        v6 [SLOTS],
	input  logic [pert_pkg::ADDR_W-1:0] addr_high [SLOTS],
	input  logic [pert_pkg::ADDR_W-1:0] addr_low [SLOTS],
	input  logic [pert_pkg::PORT_W-1:0] port [SLOTS],
	input  logic                        src_v6,
	input  logic [pert_pkg::ADDR_W-1:0] src_high,
	input  logic [pert_pkg::ADDR_W-1:0] src_low,
	input  logic [pert_pkg::PORT_W-1:0] src_port,
	output logic                        hit,
	output logic [IDX_W-1:0]            idx
);
	import pert_pkg::*;

	logic [SLOTS-1:0] slot_hit;
	logic             mapped_src;

	// v4-mapped IPv6 source: ::ffff:a.b.c.d
	assign mapped_src = src_v6 && (src_high == '0) && (src_low[63:32] == MAPPED_PREFIX);

	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			slot_hit[s] = valid[s] && (
				(v6[s] == src_v6 && addr_high[s] == src_high &&
				 addr_low[s] == src_low && port[s] == src_port) ||
				(!v6[s] && mapped_src && port[s] == src_port &&
				 addr_low[s][63:32] == '0 && addr_low[s][31:0] == src_low[31:0]));
		end
	end

	// lowest matching slot wins
	always_comb begin
		hit = |slot_hit;
		idx = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (slot_hit[s]) begin
				idx = IDX_W'(s);
			end
		end
	end

endmodule

// ===== design/pert_table.sv =====
// Peer table state, command decode, counter updates and result build.
`include "paired_endpoint_relay_table_core_macros.svh"

module pert_table #(
	parameter int SLOTS = pert_pkg::PEER_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  pert_pkg::in_item_t  item,
	output pert_pkg::out_item_t result
);
	import pert_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);

	logic              valid_q [SLOTS];
	logic              v6_q [SLOTS];
	logic [ADDR_W-1:0] addr_high_q [SLOTS];
	logic [ADDR_W-1:0] addr_low_q [SLOTS];
	logic [PORT_W-1:0] port_q [SLOTS];
	logic              linked_q [SLOTS];
	logic [IDX_W-1:0]  partner_q [SLOTS];
	logic [CNT_W-1:0]  rx_bytes_q [SLOTS];
	logic [CNT_W-1:0]  fwd_bytes_q [SLOTS];
	logic [63:0]       last_seen_q [SLOTS];
	logic [CNT_W-1:0]  rx_pkts_q;
	logic [CNT_W-1:0]  fwd_pkts_q;
	logic [CNT_W-1:0]  unknown_drops_q;
	logic [CNT_W-1:0]  nolink_drops_q;

	logic [ADDR_W-1:0] src_high;
	logic [ADDR_W-1:0] src_low;
	logic              hit;
	logic [IDX_W-1:0]  src_idx;
	logic [IDX_W-1:0]  peer_idx;
	logic              fwd;
	logic [IDX_W-1:0]  a_idx;
	logic [IDX_W-1:0]  b_idx;
	logic              a_in_range;
	logic              b_in_range;
	logic              a_ok;
	logic              b_ok;
	logic [IDX_W-1:0]  a_partner;
	logic [IDX_W-1:0]  ep_idx;
	logic [IDX_W-1:0]  cnt_idx;
	logic [CNT_W-1:0]  len_ext;

	assign src_high = item.is_v6 ? item.address_high : '0;
	assign src_low  = item.is_v6 ? item.address_low : {32'b0, item.address_low[31:0]};
	assign len_ext  = CNT_W'(item.packet_length);

	pert_match #(
		.SLOTS (SLOTS),
		.IDX_W (IDX_W)
	) u_match (
		.valid     (valid_q),
		.v6        (v6_q),
		.addr_high (addr_high_q),
		.addr_low  (addr_low_q),
		.port      (port_q),
		.src_v6    (item.is_v6),
		.src_high  (src_high),
		.src_low   (src_low),
		.src_port  (item.port_number),
		.hit       (hit),
		.idx       (src_idx)
	);

	assign peer_idx   = partner_q[src_idx];
	assign fwd        = linked_q[src_idx] && valid_q[peer_idx];
	assign a_idx      = IDX_W'(item.slot_a);
	assign b_idx      = IDX_W'(item.slot_b);
	assign a_in_range = 32'(item.slot_a) < SLOTS;
	assign b_in_range = 32'(item.slot_b) < SLOTS;
	assign a_ok       = a_in_range && valid_q[a_idx];
	assign b_ok       = b_in_range && valid_q[b_idx];
	assign a_partner  = partner_q[a_idx];
	assign ep_idx     = (item.command == CMD_PACKET) ? peer_idx : a_idx;
	assign cnt_idx    = (item.command == CMD_PACKET) ? src_idx : a_idx;

	always_comb begin
		result = '0;
		unique case (item.command)
			CMD_PACKET: begin
				if (!hit) begin
					result.status = ST_UNKNOWN;
				end else begin
					result.source_slot = SLOT_W'(src_idx);
					if (fwd) begin
						result.status            = ST_OK;
						result.dest_slot         = SLOT_W'(peer_idx);
						result.dest_address_high = addr_high_q[ep_idx];
						result.dest_address_low  = addr_low_q[ep_idx];
						result.dest_port         = port_q[ep_idx];
						result.dest_is_v6        = v6_q[ep_idx];
					end else begin
						result.status = ST_NO_LINK;
					end
				end
			end
			CMD_PEER_ADD: begin
				result.source_slot = item.slot_a;
				if (!a_in_range) begin
					result.status = ST_UNKNOWN;
				end else if (valid_q[a_idx]) begin
					result.status = ST_TAKEN;
				end
			end
			CMD_PEER_REMOVE: begin
				result.source_slot = item.slot_a;
				if (!a_ok) begin
					result.status = ST_NOT_FOUND;
				end
			end
			CMD_LINK_ADD: begin
				result.source_slot = item.slot_a;
				result.dest_slot   = item.slot_b;
				if (item.slot_a == item.slot_b) begin
					result.status = ST_SELF_LINK;
				end else if (!a_ok || !b_ok) begin
					result.status = ST_UNKNOWN;
				end else if (linked_q[a_idx] && a_partner == b_idx) begin
					result.status = ST_DUP_LINK;
				end else if (linked_q[a_idx] || linked_q[b_idx]) begin
					result.status = ST_LINKED;
				end
			end
			CMD_LINK_REMOVE: begin
				result.source_slot = item.slot_a;
				result.dest_slot   = item.slot_b;
				if (!a_ok || !b_ok || !linked_q[a_idx] || a_partner != b_idx) begin
					result.status = ST_NO_LINK;
				end
			end
			CMD_PEER_READ: begin
				result.source_slot = item.slot_a;
				if (!a_ok) begin
					result.status = ST_NOT_FOUND;
				end else begin
					if (linked_q[a_idx]) begin
						result.dest_slot = SLOT_W'(a_partner);
					end
					result.dest_address_high = addr_high_q[ep_idx];
					result.dest_address_low  = addr_low_q[ep_idx];
					result.dest_port         = port_q[ep_idx];
					result.dest_is_v6        = v6_q[ep_idx];
					result.value_a           = rx_bytes_q[cnt_idx];
					result.value_b           = fwd_bytes_q[cnt_idx];
					result.value_c           = last_seen_q[cnt_idx];
					result.value_d           = CNT_W'(linked_q[a_idx]);
				end
			end
			CMD_STATS_READ: begin
				result.value_a = rx_pkts_q;
				result.value_b = fwd_pkts_q;
				result.value_c = unknown_drops_q;
				result.value_d = nolink_drops_q;
			end
			default: begin
				result.status = ST_NOT_FOUND;
			end
		endcase
	end

	// endpoint store: written on peer add only, no reset
	always_ff @(posedge clk) begin
		if (advance && item.command == CMD_PEER_ADD && result.status == ST_OK) begin
			addr_high_q[a_idx] <= src_high;
			addr_low_q[a_idx]  <= src_low;
			port_q[a_idx]      <= item.port_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				valid_q[s]     <= 1'b0;
				v6_q[s]        <= 1'b0;
				linked_q[s]    <= 1'b0;
				partner_q[s]   <= '0;
				rx_bytes_q[s]  <= '0;
				fwd_bytes_q[s] <= '0;
				last_seen_q[s] <= '0;
			end
			rx_pkts_q       <= '0;
			fwd_pkts_q      <= '0;
			unknown_drops_q <= '0;
			nolink_drops_q  <= '0;
		end else if (advance) begin
			unique case (item.command)
				CMD_PACKET: begin
					rx_pkts_q <= rx_pkts_q + 1'b1;
					if (!hit) begin
						unknown_drops_q <= unknown_drops_q + 1'b1;
					end else begin
						rx_bytes_q[cnt_idx]  <= rx_bytes_q[cnt_idx] + len_ext;
						last_seen_q[cnt_idx] <= item.timestamp;
						if (fwd) begin
							fwd_pkts_q           <= fwd_pkts_q + 1'b1;
							fwd_bytes_q[cnt_idx] <= fwd_bytes_q[cnt_idx] + len_ext;
						end else begin
							nolink_drops_q <= nolink_drops_q + 1'b1;
						end
					end
				end
				CMD_PEER_ADD: begin
					if (result.status == ST_OK) begin
						valid_q[a_idx]     <= 1'b1;
						v6_q[a_idx]        <= item.is_v6;
						linked_q[a_idx]    <= 1'b0;
						partner_q[a_idx]   <= '0;
						rx_bytes_q[a_idx]  <= '0;
						fwd_bytes_q[a_idx] <= '0;
						last_seen_q[a_idx] <= '0;
					end
				end
				CMD_PEER_REMOVE: begin
					if (result.status == ST_OK) begin
						// drop the partner's side of the link too
						if (linked_q[a_idx]) begin
							linked_q[a_partner]  <= 1'b0;
							partner_q[a_partner] <= '0;
						end
						valid_q[a_idx]   <= 1'b0;
						linked_q[a_idx]  <= 1'b0;
						partner_q[a_idx] <= '0;
					end
				end
				CMD_LINK_ADD: begin
					if (result.status == ST_OK) begin
						linked_q[a_idx]  <= 1'b1;
						partner_q[a_idx] <= b_idx;
						linked_q[b_idx]  <= 1'b1;
						partner_q[b_idx] <= a_idx;
					end
				end
				CMD_LINK_REMOVE: begin
					if (result.status == ST_OK) begin
						linked_q[a_idx]  <= 1'b0;
						partner_q[a_idx] <= '0;
						linked_q[b_idx]  <= 1'b0;
						partner_q[b_idx] <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_link_chk
		`PERT_ASSERT(a_linked_valid, clk, arst_n, linked_q[g] |-> valid_q[g] && valid_q[partner_q[g]], "linked slot or its partner not valid")
		`PERT_ASSERT(a_linked_mutual, clk, arst_n, linked_q[g] |-> linked_q[partner_q[g]] && partner_q[partner_q[g]] == IDX_W'(g), "link not mutual")
		`PERT_ASSERT(a_no_self_link, clk, arst_n, linked_q[g] |-> partner_q[g] != IDX_W'(g), "slot linked to itself")
	end

endmodule

// ===== design/paired_endpoint_relay_table_core.sv =====
// Top level of the relay forwarding table: input register, table, result register.
//
// Usage: commands enter on the item channel (item_valid, item_stall, item) and one
// result per command leaves on the result channel (result_valid, result_stall,
// result). A transfer happens at a rising edge where valid is high and stall low.
// Every command, packet lookups included, gives exactly one result.
// A transferred command sits in the input register, is processed by the table
// when it advances and is then written into the result register.
// Throughput: one command per cycle unless result_stall holds a result. Lookup,
// counter update and table change all happen in the single cycle in which the
// command advances, set by the parallel endpoint compare over all peer slots
// followed by the 64-bit counter adders.
// Commands act in transfer order; each one sees every table change of those
// before it.
// Reset clears all peers, links and counters at once; the block takes commands
// as soon as reset is released.
// While result_stall holds a finished result, one further command is taken
// into the input register, then item_stall rises until the result moves on.
`include "paired_endpoint_relay_table_core_macros.svh"

module paired_endpoint_relay_table_core #(
	parameter int PEER_SLOTS = pert_pkg::PEER_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  pert_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output pert_pkg::out_item_t result
);
	import pert_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_q;
	logic      result_valid_q;
	out_item_t table_result;
	logic      advance;
	logic      accept;

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	pert_table #(
		.SLOTS (PEER_SLOTS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.result  (table_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= table_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`PERT_ASSERT(a_free_path, clk, arst_n, valid_s1 && !result_valid_q |-> advance, "held command with empty result register")
	`PERT_ASSERT(a_accept_lands, clk, arst_n, accept |=> valid_s1, "transferred command lost")
	`PERT_ASSERT(a_stall_holds, clk, arst_n, valid_s1 && result_valid_q && result_stall |=> valid_s1 && result_valid_q, "stall dropped a command or result")

endmodule
